>>> src/cal_pkg.sv
// Shared types, codes and constants for the climate alarm level block.
// Used by the channel interfaces and every module under src.
package cal_pkg;

	// Field widths
	localparam int TEMP_W   = 11;
	localparam int HUM_W    = 10;
	localparam int NH3_W    = 10;
	localparam int CO2_W    = 14;
	localparam int MASK_W   = 3;
	localparam int LEVEL_W  = 2;
	localparam int INDEX_W  = 11;
	localparam int THI_W    = 22;   // signed, covers -400000 .. 1850000
	localparam int SCALED_W = 21;   // register * 1000, up to 2047000
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 14;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TEMP_EMERGENCY    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TEMP_WARN         = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_AMMONIA_EMERGENCY = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_AMMONIA_WARN      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CO2_EMERGENCY     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CO2_CAUTION       = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_INDEX_EMERGENCY   = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_INDEX_WARN        = 3'd7;

	// Alarm levels and masks
	localparam logic [LEVEL_W-1:0] LEVEL_SAFE  = 2'd0;
	localparam logic [LEVEL_W-1:0] LEVEL_WARN  = 2'd1;
	localparam logic [LEVEL_W-1:0] LEVEL_EMERG = 2'd2;
	localparam logic [MASK_W-1:0]  MASK_NONE   = 3'd0;
	localparam logic [MASK_W-1:0]  MASK_WARN   = 3'd1;
	localparam logic [MASK_W-1:0]  MASK_EMERG  = 3'd7;

	// Saturation limits
	localparam logic signed [TEMP_W-1:0] TEMP_MIN = -11'sd400;
	localparam logic signed [TEMP_W-1:0] TEMP_MAX = 11'sd850;
	localparam logic [HUM_W-1:0] HUM_MAX = 10'd1000;
	localparam logic [NH3_W-1:0] NH3_MAX = 10'd1000;
	localparam logic [CO2_W-1:0] CO2_MAX = 14'd10000;

	// Fixed clear limits
	localparam logic signed [TEMP_W-1:0] CLEAR_TEMP  = 11'sd300;
	localparam logic signed [THI_W-1:0]  CLEAR_INDEX = 22'sd700000;
	localparam logic [NH3_W-1:0] CLEAR_AMMONIA = 10'd18;
	localparam logic [CO2_W-1:0] CLEAR_CO2     = 14'd2500;

	// Index arithmetic: thi = 800*t + h*(t-144) + 464000
	localparam logic signed [THI_W-1:0] THI_TEMP_GAIN = 22'sd800;
	localparam logic signed [THI_W-1:0] THI_TEMP_OFS  = 22'sd144;
	localparam logic signed [THI_W-1:0] THI_BASE      = 22'sd464000;
	localparam logic signed [THI_W-1:0] THI_ROUND     = 22'sd500;
	localparam logic [INDEX_W-1:0]      INDEX_MAX     = 11'd1850;
	// floor(x/1000) = (x * RECIP_1000) >> RECIP_SHIFT for x < 2^21
	localparam int RECIP_SHIFT = 31;
	localparam int RECIP_W     = 22;
	localparam logic [RECIP_W-1:0] RECIP_1000 = 22'd2147484;
	localparam int QPROD_W = SCALED_W + RECIP_W;

	// Register reset values
	localparam logic signed [TEMP_W-1:0] RST_TEMP_EMERGENCY = 11'sd350;
	localparam logic signed [TEMP_W-1:0] RST_TEMP_WARN      = 11'sd320;
	localparam logic [NH3_W-1:0]    RST_AMMONIA_EMERGENCY = 10'd25;
	localparam logic [NH3_W-1:0]    RST_AMMONIA_WARN      = 10'd20;
	localparam logic [CO2_W-1:0]    RST_CO2_EMERGENCY     = 14'd5000;
	localparam logic [CO2_W-1:0]    RST_CO2_CAUTION       = 14'd3000;
	localparam logic [SCALED_W-1:0] RST_INDEX_EMERGENCY   = 21'd780000;
	localparam logic [SCALED_W-1:0] RST_INDEX_WARN        = 21'd720000;

	// Configuration, index thresholds kept pre-scaled by 1000
	typedef struct packed {
		logic signed [TEMP_W-1:0] temp_emergency;
		logic signed [TEMP_W-1:0] temp_warn;
		logic [NH3_W-1:0]    ammonia_emergency;
		logic [NH3_W-1:0]    ammonia_warn;
		logic [CO2_W-1:0]    co2_emergency;
		logic [CO2_W-1:0]    co2_caution;
		logic [SCALED_W-1:0] index_emergency_scaled;
		logic [SCALED_W-1:0] index_warn_scaled;
	} cfg_t;

	// Raw input beat
	typedef struct packed {
		logic                     climate_present;
		logic signed [TEMP_W-1:0] temperature;
		logic [HUM_W-1:0]         humidity;
		logic                     ammonia_present;
		logic [NH3_W-1:0]         ammonia;
		logic                     co2_present;
		logic [CO2_W-1:0]         co2;
		logic                     apply_drive;
		logic                     manual_active;
		logic [MASK_W-1:0]        manual_mask;
	} raw_t;

	// Saturated readings plus index
	typedef struct packed {
		logic                     climate_present;
		logic signed [TEMP_W-1:0] temperature;
		logic signed [THI_W-1:0]  thi;
		logic                     ammonia_present;
		logic [NH3_W-1:0]         ammonia;
		logic                     co2_present;
		logic [CO2_W-1:0]         co2;
		logic                     apply_drive;
		logic                     manual_active;
		logic [MASK_W-1:0]        manual_mask;
	} mid_t;

	// Result beat
	typedef struct packed {
		logic [LEVEL_W-1:0] level;
		logic [MASK_W-1:0]  actuator_mask;
		logic [INDEX_W-1:0] index_tenths;
		logic               drive_update;
	} res_t;

endpackage

>>> src/cal_ifs.sv
// Valid/ready channel interfaces for sensor records and alarm results.
// Depends on cal_pkg for field widths.
interface cal_sample_if
	import cal_pkg::*;
();
	logic                     valid;
	logic                     ready;
	logic                     climate_present;
	logic signed [TEMP_W-1:0] temperature;
	logic [HUM_W-1:0]         humidity;
	logic                     ammonia_present;
	logic [NH3_W-1:0]         ammonia;
	logic                     co2_present;
	logic [CO2_W-1:0]         co2;
	logic                     apply_drive;
	logic                     manual_active;
	logic [MASK_W-1:0]        manual_mask;

	modport source (
		output valid, climate_present, temperature, humidity, ammonia_present,
			ammonia, co2_present, co2, apply_drive, manual_active, manual_mask,
		input ready
	);
	modport sink (
		input valid, climate_present, temperature, humidity, ammonia_present,
			ammonia, co2_present, co2, apply_drive, manual_active, manual_mask,
		output ready
	);
endinterface

interface cal_result_if
	import cal_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [LEVEL_W-1:0] level;
	logic [MASK_W-1:0]  actuator_mask;
	logic [INDEX_W-1:0] index_tenths;
	logic               drive_update;

	modport source (
		output valid, level, actuator_mask, index_tenths, drive_update,
		input ready
	);
	modport sink (
		input valid, level, actuator_mask, index_tenths, drive_update,
		output ready
	);
endinterface

>>> src/climate_alarm_level_hysteresis.sv
// Top level: three-stage climate alarm pipeline with hysteresis level register.
// Depends on cal_pkg, cal_ifs, cal_cfg_regs, cal_thi_calc, cal_level_eval.
//
//  channel  | dir | beat contents
//  ---------+-----+------------------------------------------------------------
//  sample   | in  | present flags, temperature, humidity, ammonia, co2, drive req
//  result   | out | level, actuator_mask, index_tenths, drive_update
//  cfg_*    | in  | register write: enable, index, data (no handshake)
//
// One record per cycle while results are taken; a record passes stages 1, 2 and 3 to result.
// Stage 1 holds the raw beat, stage 2 the saturated readings and the index
// (one multiply), stage 3 the result (compares, level, reciprocal multiply).
// Reset clears all valid bits and the held level (safe), and loads default thresholds.
// A stalled result holds its stage; upstream stages keep filling until full.
module climate_alarm_level_hysteresis
	import cal_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	cal_sample_if.sink            sample,
	cal_result_if.source          result,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	cfg_t cfg;
	raw_t raw_in;
	raw_t raw_s1;
	mid_t mid_next;
	mid_t mid_s2;
	res_t res_next;
	res_t res_s3;
	logic v_s1;
	logic v_s2;
	logic v_s3;
	logic en_s1;
	logic en_s2;
	logic en_s3;
	logic [LEVEL_W-1:0] level_q;

	cal_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// stage enables, ready ripples back through empty stages
	assign en_s3 = !v_s3 || result.ready;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;
	assign sample.ready = en_s1;

	assign raw_in.climate_present = sample.climate_present;
	assign raw_in.temperature     = sample.temperature;
	assign raw_in.humidity        = sample.humidity;
	assign raw_in.ammonia_present = sample.ammonia_present;
	assign raw_in.ammonia         = sample.ammonia;
	assign raw_in.co2_present     = sample.co2_present;
	assign raw_in.co2             = sample.co2;
	assign raw_in.apply_drive     = sample.apply_drive;
	assign raw_in.manual_active   = sample.manual_active;
	assign raw_in.manual_mask     = sample.manual_mask;

	cal_thi_calc u_thi (
		.raw (raw_s1),
		.mid (mid_next)
	);

	cal_level_eval u_eval (
		.mid           (mid_s2),
		.cfg           (cfg),
		.current_level (level_q),
		.res           (res_next)
	);

	// valid bits and held level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			level_q <= LEVEL_SAFE;
		end else begin
			if (en_s1)
				v_s1 <= sample.valid;
			if (en_s2)
				v_s2 <= v_s1;
			if (en_s3)
				v_s3 <= v_s2;
			if (en_s3 && v_s2)
				level_q <= res_next.level;
		end
	end

	// payload stages
	always_ff @(posedge clk) begin
		if (en_s1 && sample.valid)
			raw_s1 <= raw_in;
		if (en_s2 && v_s1)
			mid_s2 <= mid_next;
		if (en_s3 && v_s2)
			res_s3 <= res_next;
	end

	assign result.valid         = v_s3;
	assign result.level         = res_s3.level;
	assign result.actuator_mask = res_s3.actuator_mask;
	assign result.index_tenths  = res_s3.index_tenths;
	assign result.drive_update  = res_s3.drive_update;

`ifndef SYNTHESIS
	// held level tracks the level shown on the output
	a_level_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (level_q == result.level))
		else $error("held level differs from reported level");

	// an accepted beat always lands in stage 1
	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(sample.valid && sample.ready) |=> v_s1)
		else $error("accepted beat lost at stage 1");

	// a stalled stage 2 keeps its contents
	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && !en_s3) |=> (v_s2 && $stable(mid_s2)))
		else $error("stage 2 changed while stalled");
`endif

endmodule

>>> src/cal_cfg_regs.sv
// Threshold registers with write port; index thresholds stored times 1000.
// Depends on cal_pkg.
module cal_cfg_regs
	import cal_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output cfg_t                  cfg
);

	logic [SCALED_W-1:0] wdata_scaled;

	// value * 1000 = value * 1024 - value * 16 - value * 8
	always_comb begin
		logic [SCALED_W-1:0] v;
		v = SCALED_W'(cfg_wdata[INDEX_W-1:0]);
		wdata_scaled = (v << 10) - (v << 4) - (v << 3);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.temp_emergency         <= RST_TEMP_EMERGENCY;
			cfg.temp_warn              <= RST_TEMP_WARN;
			cfg.ammonia_emergency      <= RST_AMMONIA_EMERGENCY;
			cfg.ammonia_warn           <= RST_AMMONIA_WARN;
			cfg.co2_emergency          <= RST_CO2_EMERGENCY;
			cfg.co2_caution            <= RST_CO2_CAUTION;
			cfg.index_emergency_scaled <= RST_INDEX_EMERGENCY;
			cfg.index_warn_scaled      <= RST_INDEX_WARN;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TEMP_EMERGENCY:    cfg.temp_emergency <= $signed(cfg_wdata[TEMP_W-1:0]);
				REG_TEMP_WARN:         cfg.temp_warn <= $signed(cfg_wdata[TEMP_W-1:0]);
				REG_AMMONIA_EMERGENCY: cfg.ammonia_emergency <= cfg_wdata[NH3_W-1:0];
				REG_AMMONIA_WARN:      cfg.ammonia_warn <= cfg_wdata[NH3_W-1:0];
				REG_CO2_EMERGENCY:     cfg.co2_emergency <= cfg_wdata[CO2_W-1:0];
				REG_CO2_CAUTION:       cfg.co2_caution <= cfg_wdata[CO2_W-1:0];
				REG_INDEX_EMERGENCY:   cfg.index_emergency_scaled <= wdata_scaled;
				REG_INDEX_WARN:        cfg.index_warn_scaled <= wdata_scaled;
				default: ;
			endcase
		end
	end

endmodule

>>> src/cal_thi_calc.sv
// Saturates one raw sensor record and forms the scaled temperature-humidity index.
// Combinational; depends on cal_pkg.
module cal_thi_calc
	import cal_pkg::*;
(
	input  raw_t raw,
	output mid_t mid
);

	logic signed [TEMP_W-1:0] t_sat;
	logic [HUM_W-1:0]         h_sat;
	logic signed [THI_W-1:0]  t_w;
	logic signed [THI_W-1:0]  h_w;
	logic signed [THI_W-1:0]  cross_term;

	// clamp readings to their ranges
	always_comb begin
		if (raw.temperature < TEMP_MIN)
			t_sat = TEMP_MIN;
		else if (raw.temperature > TEMP_MAX)
			t_sat = TEMP_MAX;
		else
			t_sat = raw.temperature;
		h_sat = (raw.humidity > HUM_MAX) ? HUM_MAX : raw.humidity;
	end

	// thi = 800*t + h*(t-144) + 464000, zero when climate absent
	assign t_w        = THI_W'(t_sat);
	assign h_w        = $signed(THI_W'(h_sat));
	assign cross_term = (t_w - THI_TEMP_OFS) * h_w;

	always_comb begin
		mid.climate_present = raw.climate_present;
		mid.temperature     = t_sat;
		mid.thi             = raw.climate_present ?
			(THI_TEMP_GAIN * t_w + cross_term + THI_BASE) : '0;
		mid.ammonia_present = raw.ammonia_present;
		mid.ammonia         = (raw.ammonia > NH3_MAX) ? NH3_MAX : raw.ammonia;
		mid.co2_present     = raw.co2_present;
		mid.co2             = (raw.co2 > CO2_MAX) ? CO2_MAX : raw.co2;
		mid.apply_drive     = raw.apply_drive;
		mid.manual_active   = raw.manual_active;
		mid.manual_mask     = raw.manual_mask;
	end

endmodule

>>> src/cal_level_eval.sv
// Threshold compares, hysteresis level decision and rounded index output.
// Combinational; depends on cal_pkg.
module cal_level_eval
	import cal_pkg::*;
(
	input  mid_t               mid,
	input  cfg_t               cfg,
	input  logic [LEVEL_W-1:0] current_level,
	output res_t               res
);

	logic emerg;
	logic warn;
	logic clear;
	logic [LEVEL_W-1:0]  lvl;
	logic [MASK_W-1:0]   mask;
	logic [SCALED_W-1:0] round_x;
	logic [QPROD_W-1:0]  qprod;
	logic [QPROD_W-RECIP_SHIFT-1:0] quot;

	// threshold hits
	always_comb begin
		emerg = (mid.climate_present && mid.temperature > cfg.temp_emergency) ||
			(mid.ammonia_present && mid.ammonia > cfg.ammonia_emergency) ||
			(mid.co2_present && mid.co2 > cfg.co2_emergency) ||
			(mid.climate_present &&
				mid.thi > $signed({1'b0, cfg.index_emergency_scaled}));
		warn = (mid.climate_present && mid.temperature > cfg.temp_warn) ||
			(mid.ammonia_present && mid.ammonia > cfg.ammonia_warn) ||
			(mid.co2_present && mid.co2 > cfg.co2_caution) ||
			(mid.climate_present &&
				mid.thi > $signed({1'b0, cfg.index_warn_scaled}));
		clear = (!mid.climate_present ||
				(mid.temperature < CLEAR_TEMP && mid.thi < CLEAR_INDEX)) &&
			(!mid.ammonia_present || mid.ammonia < CLEAR_AMMONIA) &&
			(!mid.co2_present || mid.co2 < CLEAR_CO2);
	end

	// level with hold until every reading clears
	always_comb begin
		if (emerg) begin
			lvl  = LEVEL_EMERG;
			mask = MASK_EMERG;
		end else if (warn) begin
			lvl  = LEVEL_WARN;
			mask = MASK_WARN;
		end else if (current_level != LEVEL_SAFE && !clear) begin
			lvl  = current_level;
			mask = (current_level == LEVEL_EMERG) ? MASK_EMERG : MASK_WARN;
		end else begin
			lvl  = LEVEL_SAFE;
			mask = MASK_NONE;
		end
	end

	// index tenths: (thi + 500) / 1000 by reciprocal multiply
	assign round_x = (mid.climate_present && !mid.thi[THI_W-1]) ?
		SCALED_W'(mid.thi + THI_ROUND) : '0;
	assign qprod = QPROD_W'(round_x) * QPROD_W'(RECIP_1000);
	assign quot  = qprod[QPROD_W-1:RECIP_SHIFT];

	always_comb begin
		res.level         = lvl;
		res.actuator_mask = mid.manual_active ? mid.manual_mask : mask;
		res.index_tenths  = (quot > (QPROD_W-RECIP_SHIFT)'(INDEX_MAX)) ?
			INDEX_MAX : quot[INDEX_W-1:0];
		res.drive_update  = mid.apply_drive && !mid.manual_active;
	end

endmodule

>>> tb/climate_alarm_level_hysteresis_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the climate alarm level block with hysteresis.
// Depends on cal_pkg, cal_ifs and the top level; a directed table, then random
// sensor records under several threshold settings and handshake idle patterns.
module climate_alarm_level_hysteresis_tb;
	import cal_pkg::*;

	localparam int QUIET_LIMIT   = 3000;   // cycles with no beat before giving up
	localparam int HOLD_CYCLES   = 80;     // long receiver hold-off
	localparam int PHASE_RECORDS = 65;
	localparam int NUM_PHASES    = 6;

	localparam logic [CFG_IDX_W-1:0] REG_ORDER [8] = '{
		REG_TEMP_EMERGENCY, REG_TEMP_WARN, REG_AMMONIA_EMERGENCY, REG_AMMONIA_WARN,
		REG_CO2_EMERGENCY, REG_CO2_CAUTION, REG_INDEX_EMERGENCY, REG_INDEX_WARN
	};

	typedef struct {
		bit   typed;
		res_t want;
	} typed_due_t;

	typedef struct {
		raw_t rec;
		bit   typed;
		res_t want;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	cal_sample_if sample ();
	cal_result_if result ();

	climate_alarm_level_hysteresis dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample    (sample),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// Predictor copy of the thresholds and the held level
	int lim_temp_em, lim_temp_warn, lim_nh3_em, lim_nh3_warn;
	int lim_co2_em, lim_co2_caution, lim_idx_em, lim_idx_warn;
	logic [LEVEL_W-1:0] held_level;

	res_t       alarm_due_q [$];
	typed_due_t typed_due_q [$];
	int  mismatch_cnt;
	int  quiet_cycles;
	int  idle_pct;
	int  stall_pct;
	bit  hold_ask;
	int  hold_left = 0;
	dir_row_t dir_tab [$];

	// Clock
	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic void limits_reset();
		lim_temp_em     = 350;
		lim_temp_warn   = 320;
		lim_nh3_em      = 25;
		lim_nh3_warn    = 20;
		lim_co2_em      = 5000;
		lim_co2_caution = 3000;
		lim_idx_em      = 780;
		lim_idx_warn    = 720;
		held_level      = LEVEL_SAFE;
	endfunction

	function automatic void limit_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
		case (idx)
			REG_TEMP_EMERGENCY:    lim_temp_em     = int'($signed(d[TEMP_W-1:0]));
			REG_TEMP_WARN:         lim_temp_warn   = int'($signed(d[TEMP_W-1:0]));
			REG_AMMONIA_EMERGENCY: lim_nh3_em      = int'(d[NH3_W-1:0]);
			REG_AMMONIA_WARN:      lim_nh3_warn    = int'(d[NH3_W-1:0]);
			REG_CO2_EMERGENCY:     lim_co2_em      = int'(d[CO2_W-1:0]);
			REG_CO2_CAUTION:       lim_co2_caution = int'(d[CO2_W-1:0]);
			REG_INDEX_EMERGENCY:   lim_idx_em      = int'(d[INDEX_W-1:0]);
			REG_INDEX_WARN:        lim_idx_warn    = int'(d[INDEX_W-1:0]);
			default: ;
		endcase
	endfunction

	// Alarm predictor: saturate, form the index, classify, apply hysteresis
	function automatic res_t predict_alarm(raw_t r);
		int t, h, nh3, co2, thi, idx;
		bit th, hn, hc, emerg, warn, clr;
		res_t o;
		logic [LEVEL_W-1:0] lvl;
		logic [MASK_W-1:0]  msk;
		th  = r.climate_present;
		hn  = r.ammonia_present;
		hc  = r.co2_present;
		t   = int'($signed(r.temperature));
		t   = (t < -400) ? -400 : ((t > 850) ? 850 : t);
		h   = int'(r.humidity);
		h   = (h > 1000) ? 1000 : h;
		nh3 = int'(r.ammonia);
		nh3 = (nh3 > 1000) ? 1000 : nh3;
		co2 = int'(r.co2);
		co2 = (co2 > 10000) ? 10000 : co2;
		thi = th ? (800 * t + h * (t - 144) + 464000) : 0;

		emerg = (th && t > lim_temp_em) || (hn && nh3 > lim_nh3_em) ||
			(hc && co2 > lim_co2_em) || (th && thi > lim_idx_em * 1000);
		warn = (th && t > lim_temp_warn) || (hn && nh3 > lim_nh3_warn) ||
			(hc && co2 > lim_co2_caution) || (th && thi > lim_idx_warn * 1000);
		clr = (!th || (t < 300 && thi < 700000)) && (!hn || nh3 < 18) &&
			(!hc || co2 < 2500);

		if (emerg) begin
			lvl = LEVEL_EMERG;
			msk = MASK_EMERG;
		end else if (warn) begin
			lvl = LEVEL_WARN;
			msk = MASK_WARN;
		end else if (held_level != LEVEL_SAFE && !clr) begin
			lvl = held_level;
			msk = (held_level == LEVEL_EMERG) ? MASK_EMERG : MASK_WARN;
		end else begin
			lvl = LEVEL_SAFE;
			msk = MASK_NONE;
		end
		held_level = lvl;

		idx = 0;
		if (th && thi >= 0) begin
			idx = (thi + 500) / 1000;
			if (idx > 1850)
				idx = 1850;
		end

		o.level         = lvl;
		o.actuator_mask = r.manual_active ? r.manual_mask : msk;
		o.index_tenths  = INDEX_W'(idx);
		o.drive_update  = r.apply_drive && !r.manual_active;
		return o;
	endfunction

	function automatic raw_t rec(bit cp, int t, int h, bit np, int a, bit op, int c,
		bit ad, bit ma, int mm);
		raw_t r;
		r.climate_present = cp;
		r.temperature     = TEMP_W'(t);
		r.humidity        = HUM_W'(h);
		r.ammonia_present = np;
		r.ammonia         = NH3_W'(a);
		r.co2_present     = op;
		r.co2             = CO2_W'(c);
		r.apply_drive     = ad;
		r.manual_active   = ma;
		r.manual_mask     = MASK_W'(mm);
		return r;
	endfunction

	function automatic void add_row(raw_t r, bit typed, res_t want);
		dir_row_t row;
		row.rec   = r;
		row.typed = typed;
		row.want  = want;
		dir_tab.push_back(row);
	endfunction

	// Random record: mostly near the thresholds, some full range, some raw bits
	function automatic raw_t rand_record();
		raw_t r;
		int   sel;
		r.climate_present = ($urandom_range(99) < 80);
		r.ammonia_present = ($urandom_range(99) < 80);
		r.co2_present     = ($urandom_range(99) < 80);
		sel = $urandom_range(9);
		if (sel < 7)
			r.temperature = TEMP_W'(250 + int'($urandom_range(150)));
		else if (sel < 9)
			r.temperature = TEMP_W'(int'($urandom_range(1250)) - 400);
		else
			r.temperature = TEMP_W'($urandom);
		r.humidity = ($urandom_range(9) < 8) ? HUM_W'($urandom_range(1000)) : HUM_W'($urandom);
		sel = $urandom_range(9);
		if (sel < 7)
			r.ammonia = NH3_W'(10 + $urandom_range(20));
		else if (sel < 9)
			r.ammonia = NH3_W'($urandom_range(1000));
		else
			r.ammonia = NH3_W'($urandom);
		sel = $urandom_range(9);
		if (sel < 7)
			r.co2 = CO2_W'(2000 + $urandom_range(4000));
		else if (sel < 9)
			r.co2 = CO2_W'($urandom_range(10000));
		else
			r.co2 = CO2_W'($urandom);
		r.apply_drive   = 1'($urandom_range(1));
		r.manual_active = ($urandom_range(99) < 15);
		r.manual_mask   = MASK_W'($urandom);
		return r;
	endfunction

	// Temperature threshold as a register word
	function automatic logic [CFG_DATA_W-1:0] tword(int t);
		logic [TEMP_W-1:0] v;
		v = TEMP_W'(t);
		return {3'b000, v};
	endfunction

	// Sender: optional idle cycles, then hold the beat until it is taken
	task automatic offer_record(raw_t r, bit typed, res_t want);
		typed_due_t td;
		while ($urandom_range(99) < idle_pct) begin
			sample.valid <= 1'b0;
			@(posedge clk);
		end
		td.typed = typed;
		td.want  = want;
		typed_due_q.push_back(td);
		sample.valid           <= 1'b1;
		sample.climate_present <= r.climate_present;
		sample.temperature     <= r.temperature;
		sample.humidity        <= r.humidity;
		sample.ammonia_present <= r.ammonia_present;
		sample.ammonia         <= r.ammonia;
		sample.co2_present     <= r.co2_present;
		sample.co2             <= r.co2;
		sample.apply_drive     <= r.apply_drive;
		sample.manual_active   <= r.manual_active;
		sample.manual_mask     <= r.manual_mask;
		@(posedge clk);
		while (!sample.ready)
			@(posedge clk);
	endtask

	// Wait until every result is back and the pipeline has emptied
	task automatic settle();
		while (alarm_due_q.size() != 0)
			@(posedge clk);
		repeat (5) @(posedge clk);
	endtask

	task automatic write_limits(logic [CFG_DATA_W-1:0] vals [8]);
		for (int i = 0; i < 8; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= REG_ORDER[i];
			cfg_wdata <= vals[i];
			limit_write(REG_ORDER[i], vals[i]);
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	// Receiver: random stalls, plus one long hold-off on request
	always @(posedge clk) begin
		if (!arst_n) begin
			result.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left = hold_left - 1;
			result.ready <= 1'b0;
		end else if (hold_ask) begin
			hold_ask  = 1'b0;
			hold_left = HOLD_CYCLES;
			result.ready <= 1'b0;
		end else begin
			result.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Monitor: predict on every input beat, check every result beat, watchdog
	always @(posedge clk) begin : monitor
		raw_t       r;
		res_t       p;
		res_t       got;
		typed_due_t td;
		bit         moved;
		if (arst_n) begin
			moved = 1'b0;
			if (sample.valid && sample.ready) begin
				moved = 1'b1;
				r.climate_present = sample.climate_present;
				r.temperature     = sample.temperature;
				r.humidity        = sample.humidity;
				r.ammonia_present = sample.ammonia_present;
				r.ammonia         = sample.ammonia;
				r.co2_present     = sample.co2_present;
				r.co2             = sample.co2;
				r.apply_drive     = sample.apply_drive;
				r.manual_active   = sample.manual_active;
				r.manual_mask     = sample.manual_mask;
				p = predict_alarm(r);
				if (typed_due_q.size() != 0) begin
					td = typed_due_q.pop_front();
					if (td.typed)
						p = td.want;
				end
				alarm_due_q.push_back(p);
			end
			if (result.valid && result.ready) begin
				moved = 1'b1;
				got.level         = result.level;
				got.actuator_mask = result.actuator_mask;
				got.index_tenths  = result.index_tenths;
				got.drive_update  = result.drive_update;
				if (alarm_due_q.size() == 0) begin
					$error("result beat with nothing expected: level %0d mask %0d index %0d",
						got.level, got.actuator_mask, got.index_tenths);
					mismatch_cnt++;
				end else begin
					p = alarm_due_q.pop_front();
					if (got.level !== p.level) begin
						$error("level: expected %0d, got %0d", p.level, got.level);
						mismatch_cnt++;
					end
					if (got.actuator_mask !== p.actuator_mask) begin
						$error("actuator_mask: expected %0d, got %0d",
							p.actuator_mask, got.actuator_mask);
						mismatch_cnt++;
					end
					if (got.index_tenths !== p.index_tenths) begin
						$error("index_tenths: expected %0d, got %0d",
							p.index_tenths, got.index_tenths);
						mismatch_cnt++;
					end
					if (got.drive_update !== p.drive_update) begin
						$error("drive_update: expected %0d, got %0d",
							p.drive_update, got.drive_update);
						mismatch_cnt++;
					end
				end
			end
			quiet_cycles = moved ? 0 : quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	// Main sequence
	initial begin : main
		logic [CFG_DATA_W-1:0] vals [8];
		int tw, aw, cw, iw;
		arst_n       = 1'b0;
		mismatch_cnt = 0;
		quiet_cycles = 0;
		idle_pct     = 0;
		stall_pct    = 0;
		hold_ask     = 1'b0;
		sample.valid           <= 1'b0;
		sample.climate_present <= 1'b0;
		sample.temperature     <= '0;
		sample.humidity        <= '0;
		sample.ammonia_present <= 1'b0;
		sample.ammonia         <= '0;
		sample.co2_present     <= 1'b0;
		sample.co2             <= '0;
		sample.apply_drive     <= 1'b0;
		sample.manual_active   <= 1'b0;
		sample.manual_mask     <= '0;
		cfg_we                 <= 1'b0;
		cfg_index              <= '0;
		cfg_wdata              <= '0;
		limits_reset();

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed table under the reset thresholds
		add_row(rec(0, 0, 0, 0, 0, 0, 0, 1, 0, 0), 1,
			'{LEVEL_SAFE, MASK_NONE, 11'd0, 1'b1});
		add_row(rec(1, 850, 1000, 0, 0, 0, 0, 0, 0, 0), 1,
			'{LEVEL_EMERG, MASK_EMERG, INDEX_MAX, 1'b0});
		// nothing present clears any held level
		add_row(rec(0, 0, 0, 0, 0, 0, 0, 1, 0, 0), 1,
			'{LEVEL_SAFE, MASK_NONE, 11'd0, 1'b1});
		// negative index reports zero
		add_row(rec(1, -400, 1000, 0, 0, 0, 0, 0, 0, 0), 1,
			'{LEVEL_SAFE, MASK_NONE, 11'd0, 1'b0});
		// out of range readings saturate
		add_row(rec(1, 1023, 1023, 0, 0, 0, 0, 0, 0, 0), 1,
			'{LEVEL_EMERG, MASK_EMERG, INDEX_MAX, 1'b0});
		add_row(rec(1, -1024, 1023, 0, 0, 0, 0, 0, 0, 0), 1,
			'{LEVEL_SAFE, MASK_NONE, 11'd0, 1'b0});
		add_row(rec(0, 0, 0, 1, 1023, 0, 0, 0, 0, 0), 1,
			'{LEVEL_EMERG, MASK_EMERG, 11'd0, 1'b0});
		// ammonia hysteresis: held, warn, held, clear
		add_row(rec(0, 0, 0, 1, 19, 0, 0, 0, 0, 0), 1,
			'{LEVEL_EMERG, MASK_EMERG, 11'd0, 1'b0});
		add_row(rec(0, 0, 0, 1, 21, 0, 0, 0, 0, 0), 1,
			'{LEVEL_WARN, MASK_WARN, 11'd0, 1'b0});
		add_row(rec(0, 0, 0, 1, 18, 0, 0, 0, 0, 0), 1,
			'{LEVEL_WARN, MASK_WARN, 11'd0, 1'b0});
		add_row(rec(0, 0, 0, 1, 17, 0, 0, 0, 0, 0), 1,
			'{LEVEL_SAFE, MASK_NONE, 11'd0, 1'b0});
		// CO2 saturates, then holds at the clear limit
		add_row(rec(0, 0, 0, 0, 0, 1, 16383, 0, 0, 0), 1,
			'{LEVEL_EMERG, MASK_EMERG, 11'd0, 1'b0});
		add_row(rec(0, 0, 0, 0, 0, 1, 2500, 0, 0, 0), 1,
			'{LEVEL_EMERG, MASK_EMERG, 11'd0, 1'b0});
		add_row(rec(0, 0, 0, 0, 0, 1, 2499, 0, 0, 0), 1,
			'{LEVEL_SAFE, MASK_NONE, 11'd0, 1'b0});
		// manual override replaces the mask and blocks the drive
		add_row(rec(0, 0, 0, 0, 0, 1, 10000, 1, 1, 5), 1,
			'{LEVEL_EMERG, 3'd5, 11'd0, 1'b0});
		add_row(rec(0, 0, 0, 0, 0, 1, 0, 1, 1, 7), 1,
			'{LEVEL_SAFE, 3'd7, 11'd0, 1'b0});
		// absent climate is ignored and reports no index
		add_row(rec(0, 850, 1000, 0, 0, 0, 0, 0, 0, 0), 1,
			'{LEVEL_SAFE, MASK_NONE, 11'd0, 1'b0});
		// index driven cases, checked by the predictor
		add_row(rec(1, 250, 600, 1, 15, 1, 1000, 1, 0, 0), 0, '0);
		add_row(rec(1, 0, 0, 1, 0, 1, 0, 1, 0, 2), 0, '0);
		add_row(rec(1, 300, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0);
		add_row(rec(1, 321, 0, 1, 0, 1, 0, 1, 0, 0), 0, '0);
		add_row(rec(1, 300, 0, 0, 0, 0, 0, 0, 1, 4), 0, '0);
		add_row(rec(1, 299, 1000, 0, 0, 0, 0, 1, 0, 0), 0, '0);
		add_row(rec(1, 299, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0);
		add_row(rec(1, -144, 500, 1, 0, 1, 0, 1, 0, 6), 0, '0);
		foreach (dir_tab[i])
			offer_record(dir_tab[i].rec, dir_tab[i].typed, dir_tab[i].want);
		sample.valid <= 1'b0;

		// Random phases, each with its own thresholds and idle pattern
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			settle();
			case (ph)
				0: vals = '{tword(350), tword(320), 14'd25, 14'd20,
					14'd5000, 14'd3000, 14'd780, 14'd720};
				1: vals = '{tword(-400), tword(-400), 14'd0, 14'd0,
					14'd0, 14'd0, 14'd0, 14'd0};
				2: vals = '{tword(850), tword(850), 14'd1000, 14'd1000,
					14'd10000, 14'd10000, 14'd1850, 14'd1850};
				3: vals = '{tword(1023), tword(-1024), 14'd1023, 14'd0,
					14'd16383, 14'd0, 14'd2047, 14'd0};
				4: begin
					tw = 250 + $urandom_range(150);
					aw = 10 + $urandom_range(20);
					cw = 2000 + $urandom_range(3000);
					iw = 650 + $urandom_range(150);
					vals = '{tword(tw + $urandom_range(60)), tword(tw),
						14'(aw + $urandom_range(10)), 14'(aw),
						14'(cw + $urandom_range(3000)), 14'(cw),
						14'(iw + $urandom_range(100)), 14'(iw)};
				end
				default: begin
					// full random words, upper bits beyond each register included
					foreach (vals[i])
						vals[i] = CFG_DATA_W'($urandom);
				end
			endcase
			write_limits(vals);
			// idle pattern: none, sender, receiver, both lightly
			case (ph % 4)
				1: begin
					idle_pct  = 75;
					stall_pct = 0;
				end
				2: begin
					idle_pct  = 0;
					stall_pct = 75;
				end
				3: begin
					idle_pct  = 25;
					stall_pct = 25;
				end
				default: begin
					idle_pct  = 0;
					stall_pct = 0;
				end
			endcase
			// no idling here, so the long hold-off backs the pipeline up
			if (ph == 4)
				hold_ask = 1'b1;
			repeat (PHASE_RECORDS)
				offer_record(rand_record(), 0, '0);
			sample.valid <= 1'b0;
		end

		settle();
		repeat (8) @(posedge clk);
		if (mismatch_cnt == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
